@@ hw/rtl/rvx_pkg.sv @@
// Shared types and constants of the RV32 instruction executor.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package rvx_pkg;

	// Default sizes, the reset value of the data window base and the upper mask.
	localparam int unsigned DataBytesDef = 4096;
	localparam int unsigned InstWordsDef = 1024;
	localparam int unsigned RegCount     = 32;
	localparam int unsigned QueueDepth   = 2;
	localparam logic [31:0] DataBaseRst  = 32'h1000_0000;
	localparam logic [31:0] UpperMask    = 32'hFFFF_F000;

	// Request kinds.
	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_STEP  = 2'd1,
		ACT_RDREG = 2'd2,
		ACT_RDMEM = 2'd3
	} action_t;

	// Major opcodes.
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;

	// Function codes.
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [6:0] F7_MUL  = 7'h01;
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BYTE = 3'd0;
	localparam logic [2:0] F3_HALF = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_REGS,
		ST_MEM,
		ST_RDREG,
		ST_OUT
	} state_t;

	// Input request as seen on the ports.
	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] address;
		logic [31:0] word;
	} req_t;

	// Result item.
	typedef struct packed {
		logic [31:0] pc_of_step;
		logic [31:0] instr_seen;
		logic [31:0] value;
		logic        reg_written;
		logic [4:0]  reg_index;
		logic        mem_written;
		logic [31:0] mem_address;
		logic        halted;
		logic        fault;
	} res_t;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		action_t     action;
		logic [31:0] address;
		logic [31:0] word;
		logic        addr_bad;
	} cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/rv32_instruction_executor.sv @@
// RV32 instruction executor: small RV32I+MUL core driven by requests.
//
// Requests enter through push/full as in_item (action, address, word): load an
// instruction word, step one instruction, read a register, or read a data word.
// Each request gives exactly one result on out_item, read like a queue head:
// valid while empty is low, taken with pop. Requests wait in a two-entry
// command queue, so the front accepts while the back end works and results
// wait in a two-entry result queue when the receiver stalls.
// The back end sequencer handles one request at a time: a step runs through
// fetch read, register read, execute and write back and result hand-off, a
// load instruction adds a data bank read. Register and data reads go through
// their RAM read to the hand-off; an instruction load, a step while halted and
// a step from a bad PC go straight to it, and the fetch of the halting zero
// word runs only the fetch read. Synchronous RAM reads set these steps.
// The data base register (cfg_we/cfg_wdata) resets to 0x1000_0000.
// After reset the back end runs a clearing pass that zeroes instruction and
// data memory; requests queue up meanwhile and are served after it.
// Depends on rvx_pkg, rvx_fifo, rvx_front and rvx_back.
`default_nettype none
module rv32_instruction_executor import rvx_pkg::*; #(
	parameter int unsigned DATA_BYTES = DataBytesDef,
	parameter int unsigned INST_WORDS = InstWordsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire req_t        in_item,
	output logic             full,
	input  wire logic        pop,
	output res_t             out_item,
	output logic             empty,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	logic [31:0] base_q;
	cmd_t cmd_in, cmd_out;
	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	res_t res;
	logic res_push, res_full;

	// Data window base register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= DataBaseRst;
		else if (cfg_we) base_q <= cfg_wdata;
	end

	rvx_front #(.INST_WORDS(INST_WORDS)) u_front (
		.req(in_item), .push(push), .full(full),
		.cmd(cmd_in), .cmd_push(cmd_push), .cmd_full(cmd_full)
	);

	rvx_fifo #(.T(cmd_t), .Depth(QueueDepth)) u_cmd_q (
		.clk(clk), .arst_n(arst_n),
		.push(cmd_push), .wdata(cmd_in), .full(cmd_full),
		.pop(cmd_pop), .rdata(cmd_out), .empty(cmd_empty)
	);

	rvx_back #(.DATA_BYTES(DATA_BYTES), .INST_WORDS(INST_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .data_base(base_q),
		.cmd(cmd_out), .cmd_empty(cmd_empty), .cmd_pop(cmd_pop),
		.res(res), .res_push(res_push), .res_full(res_full)
	);

	rvx_fifo #(.T(res_t), .Depth(QueueDepth)) u_res_q (
		.clk(clk), .arst_n(arst_n),
		.push(res_push), .wdata(res), .full(res_full),
		.pop(pop), .rdata(out_item), .empty(empty)
	);

	// The back end never pushes into a full result queue.
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result pushed while queue full");

	// The back end only takes a command that is present.
	a_no_cmd_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty) else $error("command taken from empty queue");

	// A reported register write never names x0.
	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.reg_written) |-> (out_item.reg_index != 5'd0))
		else $error("register write reported for x0");

endmodule
`default_nettype wire

@@ hw/rtl/rvx_fifo.sv @@
// Small synchronous queue used between front end, back end and result port.
// Depends on rvx_pkg for the default depth; Depth must be a power of two.
`default_nettype none
module rvx_fifo import rvx_pkg::*; #(
	parameter type T = logic,
	parameter int unsigned Depth = QueueDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire T     wdata,
	output logic      full,
	input  wire logic pop,
	output T          rdata,
	output logic      empty
);

	localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	T                slot_q [Depth];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == CntW'(Depth));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wdata;
	end

endmodule
`default_nettype wire

@@ hw/rtl/rvx_front.sv @@
// Front end: takes and classifies requests, flagging bad load and register addresses.
// Depends on rvx_pkg; feeds the command queue in front of rvx_back.
`default_nettype none
module rvx_front import rvx_pkg::*; #(
	parameter int unsigned INST_WORDS = InstWordsDef
) (
	input  wire req_t req,
	input  wire logic push,
	output logic      full,
	output cmd_t      cmd,
	output logic      cmd_push,
	input  wire logic cmd_full
);

	logic load_bad, reg_bad;

	// A load needs a word-aligned address inside instruction memory.
	assign load_bad = (req.address[1:0] != 2'b00) ||
		({2'b00, req.address[31:2]} >= 32'(INST_WORDS));
	// A register read needs an index below the register count.
	assign reg_bad = (req.address >= 32'(RegCount));

	always_comb begin
		cmd.action  = action_t'(req.action);
		cmd.address = req.address;
		cmd.word    = req.word;
		case (action_t'(req.action))
			ACT_LOAD:  cmd.addr_bad = load_bad;
			ACT_RDREG: cmd.addr_bad = reg_bad;
			default:   cmd.addr_bad = 1'b0;
		endcase
	end

	assign full     = cmd_full;
	assign cmd_push = push;

endmodule
`default_nettype wire

@@ hw/rtl/rvx_back.sv @@
// Back end: sequencer that executes commands against PC, register file and memories.
// Depends on rvx_pkg; takes commands from a queue and pushes results into another.
`default_nettype none
module rvx_back import rvx_pkg::*; #(
	parameter int unsigned DATA_BYTES = DataBytesDef,
	parameter int unsigned INST_WORDS = InstWordsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] data_base,
	input  wire cmd_t        cmd,
	input  wire logic        cmd_empty,
	output logic             cmd_pop,
	output res_t             res,
	output logic             res_push,
	input  wire logic        res_full
);

	localparam int unsigned IW    = $clog2(INST_WORDS);
	localparam int unsigned Rows  = (DATA_BYTES + 3) / 4;
	localparam int unsigned RW    = $clog2(Rows);
	localparam int unsigned AW    = RW + 2;
	localparam int unsigned ClrN  = (Rows > INST_WORDS) ? Rows : INST_WORDS;
	localparam int unsigned CW    = $clog2(ClrN + 1);

	state_t state_q, state_d;
	logic [31:0] pc_q, pc_d;
	logic        halt_q, halt_d;
	logic [CW-1:0] clr_q;
	logic [RegCount-1:0] rf_vld_q;
	res_t        res_q, res_d;
	logic        res_ld;
	logic [31:0] instr_q;
	action_t     act_q;
	logic [1:0]  mem_off_q;

	// Memories and their ports.
	logic [31:0] imem [INST_WORDS];
	logic [31:0] imem_rd_q;
	logic [IW-1:0] im_addr;
	logic        im_we;
	logic [31:0] rf_mem [RegCount];
	logic [31:0] rf_rd1_q, rf_rd2_q;
	logic        rf_v1_q, rf_v2_q;
	logic [4:0]  rf_ra1, rf_ra2, rf_wa;
	logic        rf_we;
	logic [31:0] rf_wd;
	logic [7:0]  dmem [4][Rows];
	logic [7:0]  bank_rd_q [4];
	logic [RW-1:0] bank_row [4];
	logic [7:0]  bank_wd [4];
	logic [3:0]  bank_we, lane_use;
	logic [1:0]  byte_i [4];
	logic [AW-1:0] lane_sum [4];

	// Decoded instruction fields.
	logic [6:0]  op, f7;
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic [31:0] rs1v, rs2v, immi, imms, jimm, bimm, alu_out, ls_addr;
	logic        br_taken, reg_wr;
	logic [31:0] reg_val;
	logic [31:0] acc_off;
	logic [2:0]  acc_n;
	logic        acc_ok, clearing;
	logic [31:0] word_rd, load_val;

	// Arithmetic for register and immediate forms.
	function automatic logic [31:0] alu_f(input logic [2:0] fn3, input logic [6:0] fn7,
		input logic [31:0] a, input logic [31:0] b, input logic reg_form);
		logic [4:0]  sh;
		logic [31:0] r;
		sh = b[4:0];
		r  = '0;
		case (fn3)
			F3_ADD: begin
				if (!reg_form || fn7 == F7_BASE) r = a + b;
				else if (fn7 == F7_ALT) r = a - b;
				else if (fn7 == F7_MUL) r = a * b;
			end
			F3_SLL: r = a << sh;
			F3_SLT: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			F3_XOR: r = a ^ b;
			F3_SR: begin
				if (fn7 == F7_BASE) r = a >> sh;
				else if (fn7 == F7_ALT) r = 32'($signed(a) >>> sh);
			end
			F3_OR:  r = a | b;
			F3_AND: r = a & b;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign op   = instr_q[6:0];
	assign rd   = instr_q[11:7];
	assign f3   = instr_q[14:12];
	assign f7   = instr_q[31:25];
	assign rs1v = rf_v1_q ? rf_rd1_q : '0;
	assign rs2v = rf_v2_q ? rf_rd2_q : '0;
	assign immi = {{20{instr_q[31]}}, instr_q[31:20]};
	assign imms = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
	assign jimm = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
		instr_q[30:21], 1'b0};
	assign bimm = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
		instr_q[11:8], 1'b0};
	assign alu_out = alu_f(f3, f7, rs1v, (op == OP_REG) ? rs2v : immi, op == OP_REG);
	assign ls_addr = rs1v + ((op == OP_STORE) ? imms : immi);
	assign clearing = (state_q == ST_CLEAR);

	// Branch condition.
	always_comb begin
		case (f3)
			F3_BEQ:  br_taken = (rs1v == rs2v);
			F3_BNE:  br_taken = (rs1v != rs2v);
			F3_BLT:  br_taken = ($signed(rs1v) < $signed(rs2v));
			F3_BGE:  br_taken = !($signed(rs1v) < $signed(rs2v));
			default: br_taken = 1'b0;
		endcase
	end

	// Data access window check and per-lane row selection.
	assign acc_off = ((state_q == ST_IDLE) ? cmd.address : ls_addr) - data_base;
	assign acc_n = (state_q == ST_IDLE || f3 == F3_WORD) ? 3'd4 :
		((f3 == F3_HALF) ? 3'd2 : 3'd1);
	assign acc_ok = ({1'b0, acc_off} + 33'(acc_n)) <= 33'(DATA_BYTES);

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			byte_i[l]   = 2'(l) - acc_off[1:0];
			lane_sum[l] = acc_off[AW-1:0] + AW'(byte_i[l]);
			lane_use[l] = ({1'b0, byte_i[l]} < acc_n);
			bank_wd[l]  = clearing ? 8'h00 : rs2v[8*byte_i[l] +: 8];
			bank_row[l] = clearing ? clr_q[RW-1:0] : lane_sum[l][AW-1:2];
		end
	end

	// Reassemble the bytes read from the four banks.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			word_rd[8*i +: 8] = bank_rd_q[2'(i) + mem_off_q];
		end
		case (f3)
			F3_BYTE: load_val = {{24{word_rd[7]}}, word_rd[7:0]};
			F3_HALF: load_val = {{16{word_rd[15]}}, word_rd[15:0]};
			default: load_val = word_rd;
		endcase
	end

	// Sequencer: next state, result and memory strobes.
	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		halt_d   = halt_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_d    = res_q;
		res_ld   = 1'b0;
		im_we    = clearing && (clr_q < CW'(INST_WORDS));
		im_addr  = clearing ? clr_q[IW-1:0] : pc_q[IW+1:2];
		bank_we  = (clearing && (clr_q < CW'(Rows))) ? 4'hF : 4'h0;
		rf_ra1   = cmd.address[4:0];
		rf_ra2   = '0;
		rf_we    = 1'b0;
		rf_wa    = rd;
		rf_wd    = '0;
		reg_wr   = 1'b0;
		reg_val  = '0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CW'(ClrN - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					res_ld  = 1'b1;
					res_d   = '0;
					res_d.pc_of_step = pc_q;
					res_d.halted     = halt_q;
					state_d = ST_OUT;
					case (cmd.action)
						ACT_LOAD: begin
							res_d.value = cmd.word;
							res_d.fault = cmd.addr_bad;
							im_addr = cmd.address[IW+1:2];
							im_we   = !cmd.addr_bad;
						end
						ACT_RDREG: begin
							res_d.fault = cmd.addr_bad;
							if (!cmd.addr_bad) state_d = ST_RDREG;
						end
						ACT_RDMEM: begin
							res_d.fault = !acc_ok;
							if (acc_ok) state_d = ST_MEM;
						end
						ACT_STEP: begin
							if (!halt_q) begin
								if (pc_q[1:0] != 2'b00 ||
									{2'b00, pc_q[31:2]} >= 32'(INST_WORDS)) begin
									res_d.fault = 1'b1;
								end else begin
									state_d = ST_FETCH;
								end
							end
						end
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_FETCH: begin
				rf_ra1 = imem_rd_q[19:15];
				rf_ra2 = imem_rd_q[24:20];
				if (imem_rd_q == '0) begin
					halt_d = 1'b1;
					res_ld = 1'b1;
					res_d.halted = 1'b1;
					state_d = ST_OUT;
				end else begin
					state_d = ST_REGS;
				end
			end
			ST_REGS: begin
				res_ld = 1'b1;
				res_d.instr_seen = instr_q;
				pc_d    = pc_q + 32'd4;
				state_d = ST_OUT;
				case (op)
					OP_REG, OP_IMM: begin
						reg_wr  = 1'b1;
						reg_val = alu_out;
					end
					OP_LUI: begin
						reg_wr  = 1'b1;
						reg_val = instr_q & UpperMask;
					end
					OP_AUIPC: begin
						reg_wr  = 1'b1;
						reg_val = pc_q + (instr_q & UpperMask);
					end
					OP_JAL: begin
						reg_wr  = 1'b1;
						reg_val = pc_q + 32'd4;
						pc_d    = pc_q + jimm;
					end
					OP_JALR: begin
						reg_wr  = 1'b1;
						reg_val = pc_q + 32'd4;
						pc_d    = (rs1v + immi) & ~32'd3;
					end
					OP_BRANCH: begin
						if (br_taken) pc_d = pc_q + bimm;
					end
					OP_LOAD: begin
						res_d.mem_address = ls_addr;
						if (f3 <= F3_WORD) begin
							if (acc_ok) state_d = ST_MEM;
							else res_d.fault = 1'b1;
						end else begin
							reg_wr = 1'b1;
						end
					end
					OP_STORE: begin
						res_d.mem_address = ls_addr;
						if (f3 <= F3_WORD) begin
							if (acc_ok) begin
								bank_we = lane_use;
								res_d.mem_written = 1'b1;
							end else begin
								res_d.fault = 1'b1;
							end
						end
					end
					default: reg_wr = 1'b0;
				endcase
				res_d.value       = reg_val;
				res_d.reg_written = reg_wr && (rd != '0);
				res_d.reg_index   = (reg_wr && (rd != '0)) ? rd : '0;
				rf_we = reg_wr && (rd != '0);
				rf_wd = reg_val;
			end
			ST_MEM: begin
				res_ld = 1'b1;
				state_d = ST_OUT;
				if (act_q == ACT_RDMEM) begin
					res_d.value = word_rd;
				end else begin
					res_d.value       = load_val;
					res_d.reg_written = (rd != '0);
					res_d.reg_index   = rd;
					rf_we = (rd != '0);
					rf_wd = load_val;
				end
			end
			ST_RDREG: begin
				res_ld = 1'b1;
				res_d.value = rs1v;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			pc_q     <= '0;
			halt_q   <= 1'b0;
			clr_q    <= '0;
			rf_vld_q <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			halt_q  <= halt_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (res_ld) res_q <= res_d;
		if (state_q == ST_FETCH) instr_q <= imem_rd_q;
		if (cmd_pop) act_q <= cmd.action;
		if (state_q == ST_IDLE || state_q == ST_REGS) mem_off_q <= acc_off[1:0];
	end

	// Instruction memory.
	always_ff @(posedge clk) begin
		if (im_we) imem[im_addr] <= clearing ? 32'd0 : cmd.word;
		imem_rd_q <= imem[im_addr];
	end

	// Register file: two registered reads, one write; valid bits stand for reset.
	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
		rf_rd1_q <= rf_mem[rf_ra1];
		rf_rd2_q <= rf_mem[rf_ra2];
		rf_v1_q  <= rf_vld_q[rf_ra1];
		rf_v2_q  <= rf_vld_q[rf_ra2];
	end

	// Data memory as four byte banks, one row address per bank.
	always_ff @(posedge clk) begin
		for (int l = 0; l < 4; l++) begin
			if (bank_we[l]) dmem[l][bank_row[l]] <= bank_wd[l];
			bank_rd_q[l] <= dmem[l][bank_row[l]];
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

@@ tb/sv/rvx_result_checker.sv @@
// Checker for the RV32 instruction executor: follows the request, result and
// configuration ports, predicts every result and compares it as a whole.
// Depends on rvx_pkg for the request, result and action types.
`default_nettype none
module rvx_result_checker import rvx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire req_t        in_item,
	input  wire logic        pop,
	input  wire logic        empty,
	input  wire res_t        out_item,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	output int               mismatches,
	output int               outstanding
);

	// Shadow copy of the core state.
	logic [31:0] shadow_pc;
	logic [31:0] shadow_regs [RegCount];
	logic [7:0]  shadow_data [DataBytesDef];
	logic [31:0] shadow_inst [InstWordsDef];
	logic        shadow_halt;
	logic [31:0] window_base;
	res_t        awaited_results [$];

	// Offset of addr inside the data window, and whether n bytes fit there.
	function automatic logic window_fit(input logic [31:0] addr, input int n,
			output logic [31:0] off);
		off = addr - window_base;
		return (64'(off) + 64'(n) <= 64'(DataBytesDef));
	endfunction

	// Little-endian read of n bytes.
	function automatic logic [31:0] data_read(input logic [31:0] off, input int n);
		logic [31:0] v;
		v = '0;
		for (int i = 0; i < n; i++)
			v[8*i +: 8] = shadow_data[off + i];
		return v;
	endfunction

	// Integer operation shared by the register and immediate forms.
	function automatic logic [31:0] int_op_calc(input logic [2:0] f3, input logic [6:0] f7,
			input logic [31:0] a, input logic [31:0] b, input logic reg_form);
		logic [4:0] sh;
		sh = b[4:0];
		case (f3)
			F3_ADD: begin
				if (!reg_form || f7 == F7_BASE) return a + b;
				if (f7 == F7_ALT) return a - b;
				if (f7 == F7_MUL) return a * b;
				return '0;
			end
			F3_SLL: return a << sh;
			F3_SLT: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			F3_XOR: return a ^ b;
			F3_SR: begin
				if (f7 == F7_BASE) return a >> sh;
				if (f7 == F7_ALT) return $unsigned($signed(a) >>> sh);
				return '0;
			end
			F3_OR:  return a | b;
			F3_AND: return a & b;
			default: return '0;
		endcase
	endfunction

	// Executes one request on the shadow state and returns its result.
	function automatic res_t serve_request(input req_t rq);
		res_t        r;
		logic [31:0] iw, rs1v, rs2v, immi, imms, nxt, off, v, jo, bo;
		logic [6:0]  opc, f7;
		logic [2:0]  f3;
		logic [4:0]  rd;
		logic        wr, taken;
		int          n;
		r = '0;
		r.pc_of_step = shadow_pc;
		case (action_t'(rq.action))
			ACT_LOAD: begin
				r.value = rq.word;
				if (rq.address[1:0] != 2'd0 || rq.address[31:2] >= InstWordsDef)
					r.fault = 1'b1;
				else
					shadow_inst[rq.address[31:2]] = rq.word;
			end
			ACT_RDREG: begin
				if (rq.address < RegCount) r.value = shadow_regs[rq.address[4:0]];
				else r.fault = 1'b1;
			end
			ACT_RDMEM: begin
				if (window_fit(rq.address, 4, off)) r.value = data_read(off, 4);
				else r.fault = 1'b1;
			end
			default: begin
				if (shadow_halt) begin
					// Nothing happens while halted.
				end else if (shadow_pc[1:0] != 2'd0 || shadow_pc[31:2] >= InstWordsDef) begin
					r.fault = 1'b1;
				end else begin
					iw = shadow_inst[shadow_pc[31:2]];
					r.instr_seen = iw;
					if (iw == '0) begin
						shadow_halt = 1'b1;
					end else begin
						opc = iw[6:0];
						rd = iw[11:7];
						f3 = iw[14:12];
						f7 = iw[31:25];
						rs1v = shadow_regs[iw[19:15]];
						rs2v = shadow_regs[iw[24:20]];
						immi = {{20{iw[31]}}, iw[31:20]};
						imms = {{20{iw[31]}}, iw[31:25], iw[11:7]};
						nxt = shadow_pc + 32'd4;
						wr = 1'b0;
						case (opc)
							OP_REG: begin
								wr = 1'b1;
								r.value = int_op_calc(f3, f7, rs1v, rs2v, 1'b1);
							end
							OP_IMM: begin
								wr = 1'b1;
								r.value = int_op_calc(f3, f7, rs1v, immi, 1'b0);
							end
							OP_LUI: begin
								wr = 1'b1;
								r.value = iw & UpperMask;
							end
							OP_AUIPC: begin
								wr = 1'b1;
								r.value = shadow_pc + (iw & UpperMask);
							end
							OP_JAL: begin
								jo = {{11{iw[31]}}, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};
								wr = 1'b1;
								r.value = shadow_pc + 32'd4;
								nxt = shadow_pc + jo;
							end
							OP_JALR: begin
								wr = 1'b1;
								r.value = shadow_pc + 32'd4;
								nxt = (rs1v + immi) & ~32'd3;
							end
							OP_BRANCH: begin
								bo = {{19{iw[31]}}, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
								case (f3)
									F3_BEQ: taken = (rs1v == rs2v);
									F3_BNE: taken = (rs1v != rs2v);
									F3_BLT: taken = ($signed(rs1v) < $signed(rs2v));
									F3_BGE: taken = !($signed(rs1v) < $signed(rs2v));
									default: taken = 1'b0;
								endcase
								if (taken) nxt = shadow_pc + bo;
							end
							OP_LOAD: begin
								r.mem_address = rs1v + immi;
								if (f3 <= F3_WORD) begin
									n = 1 << f3;
									if (!window_fit(r.mem_address, n, off)) begin
										r.fault = 1'b1;
									end else begin
										v = data_read(off, n);
										wr = 1'b1;
										case (f3)
											F3_BYTE: r.value = {{24{v[7]}}, v[7:0]};
											F3_HALF: r.value = {{16{v[15]}}, v[15:0]};
											default: r.value = v;
										endcase
									end
								end else begin
									wr = 1'b1;
									r.value = '0;
								end
							end
							OP_STORE: begin
								r.mem_address = rs1v + imms;
								if (f3 <= F3_WORD) begin
									n = 1 << f3;
									if (!window_fit(r.mem_address, n, off)) begin
										r.fault = 1'b1;
									end else begin
										for (int i = 0; i < n; i++)
											shadow_data[off + i] = rs2v[8*i +: 8];
										r.mem_written = 1'b1;
									end
								end
							end
							default: begin
							end
						endcase
						// A write to x0 is reported as no write at all.
						if (wr && rd != 5'd0) begin
							shadow_regs[rd] = r.value;
							r.reg_written = 1'b1;
							r.reg_index = rd;
						end
						shadow_pc = nxt;
					end
				end
			end
		endcase
		r.halted = shadow_halt;
		return r;
	endfunction

	// Reset state of the shadow copy.
	initial begin
		shadow_pc = '0;
		shadow_halt = 1'b0;
		window_base = DataBaseRst;
		foreach (shadow_regs[i]) shadow_regs[i] = '0;
		foreach (shadow_data[i]) shadow_data[i] = '0;
		foreach (shadow_inst[i]) shadow_inst[i] = '0;
		mismatches = 0;
		outstanding = 0;
	end

	// Compare delivered results first, then predict newly accepted requests.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result %h", out_item);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (out_item !== want) begin
						if (mismatches < 10)
							$display("result mismatch: expected %h actual %h", want, out_item);
						mismatches++;
					end
				end
			end
			if (cfg_we) window_base = cfg_wdata;
			if (push && !full) awaited_results.push_back(serve_request(in_item));
			outstanding = awaited_results.size();
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Top of the executor testbench: clock, reset, request stimulus and verdict.
// Depends on rvx_pkg, rv32_instruction_executor and rvx_result_checker.
`default_nettype none
module testbench import rvx_pkg::*;;

	localparam logic [31:0] ProgBase   = 32'h40;
	localparam int          ProgSlots  = 32;
	localparam logic [31:0] HaltSpot   = 32'h3F0;
	localparam int          CycleLimit = 400000;
	localparam logic [6:0]  OpFence    = 7'h0F;
	localparam logic [6:0]  OpSystem   = 7'h73;
	localparam logic [6:0]  OpCustom   = 7'h5B;
	localparam logic [6:0]  OpAllOnes  = 7'h7F;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	req_t        in_item = '0;
	logic        full;
	logic        pop = 1'b0;
	res_t        out_item;
	logic        empty;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	int          mismatches;
	int          outstanding;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          cycles = 0;

	rv32_instruction_executor i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .in_item(in_item), .full(full),
		.pop(pop), .out_item(out_item), .empty(empty),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	rvx_result_checker i_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.pop(pop), .empty(empty), .out_item(out_item), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .mismatches(mismatches), .outstanding(outstanding)
	);

	always #1 clk = ~clk;

	// Receiver stalls at the chosen rate.
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= stall_pct);
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Instruction encoders.
	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OP_REG};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [31:0] off, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(logic [31:0] off, logic [4:0] rd);
		return {off[20], off[10:1], off[11], off[19:12], rd, OP_JAL};
	endfunction

	// Random instruction for one program slot; control flow stays in the program area.
	function automatic logic [31:0] random_instr(int slot, logic [19:0] ptr_hi);
		logic [4:0]  rd, rs1, rs2, mrs1;
		logic [2:0]  f3, mf3;
		logic [6:0]  f7;
		logic [11:0] imm;
		logic [31:0] off;
		logic [6:0]  odd_ops [4];
		int          dest;
		odd_ops = '{OpFence, OpSystem, OpCustom, OpAllOnes};
		rd = 5'($urandom_range(0, 31));
		rs1 = 5'($urandom_range(0, 31));
		rs2 = 5'($urandom_range(0, 31));
		f3 = 3'($urandom_range(0, 7));
		imm = 12'($urandom);
		dest = $urandom_range(0, ProgSlots - 1);
		off = 32'((dest - slot) * 4);
		case ($urandom_range(0, 3))
			0: f7 = F7_BASE;
			1: f7 = F7_ALT;
			2: f7 = F7_MUL;
			default: f7 = 7'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: mrs1 = 5'd1;
			6, 7, 8: mrs1 = 5'd0;
			default: mrs1 = rs1;
		endcase
		mf3 = ($urandom_range(0, 3) == 0) ? f3 : 3'($urandom_range(0, 2));
		case ($urandom_range(0, 19))
			0, 1, 2: return enc_r(f7, rs2, rs1, f3, rd);
			3, 4, 5: begin
				if (f3 == F3_SLL || f3 == F3_SR) imm[11:5] = f7;
				return enc_i(imm, rs1, f3, rd, OP_IMM);
			end
			6: return {20'($urandom), rd, OP_LUI};
			7: return {ptr_hi, 5'd1, OP_LUI};
			8: return {20'($urandom), rd, OP_AUIPC};
			9, 10: return enc_b(off, 5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)), f3);
			11: return enc_j(off, rd);
			12: return enc_i(12'(ProgBase + dest * 4 + $urandom_range(0, 3)), 5'd0, 3'd0, rd,
				OP_JALR);
			13, 14, 15: return enc_i(imm, mrs1, mf3, rd, OP_LOAD);
			16, 17: return enc_s(imm, rs2, mrs1, mf3);
			18: return {25'($urandom), odd_ops[$urandom_range(0, 3)]};
			default: return enc_i(imm, 5'd1, F3_ADD, 5'd1, OP_IMM);
		endcase
	endfunction

	// Sends one request and returns at the falling edge after it is taken.
	task automatic send_request(action_t act, logic [31:0] addr, logic [31:0] wrd);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		in_item = '{action: act, address: addr, word: wrd};
		do begin
			@(posedge clk);
			taken = !full;
		end while (!taken);
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic load_slot(int slot, logic [31:0] instr);
		send_request(ACT_LOAD, ProgBase + 32'(slot * 4), instr);
	endtask

	task automatic step_core();
		send_request(ACT_STEP, $urandom, $urandom);
	endtask

	// Waits for every expected result, lets the core settle, then rewrites the base.
	task automatic set_window(logic [31:0] base);
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = base;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		logic [31:0] bases [4];
		logic [31:0] base, addr;
		logic [19:0] ptr_hi;
		int          ph, wait_cycles;
		bases = '{32'h0, 32'hFFFF_F800, 32'hFFFF_FFFF, $urandom};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed program under the reset window base.
		set_window(DataBaseRst);
		send_request(ACT_LOAD, 32'h0, enc_j(ProgBase, 5'd0));
		load_slot(0, {20'h10000, 5'd1, OP_LUI});
		load_slot(1, enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM));
		load_slot(2, enc_i(12'h001, 5'd0, F3_ADD, 5'd3, OP_IMM));
		load_slot(3, enc_r(F7_BASE, 5'd3, 5'd2, F3_SLT, 5'd4));
		load_slot(4, enc_i({F7_ALT, 5'd4}, 5'd2, F3_SR, 5'd5, OP_IMM));
		load_slot(5, enc_r(F7_MUL, 5'd2, 5'd2, F3_ADD, 5'd6));
		load_slot(6, enc_s(12'h0, 5'd2, 5'd1, F3_WORD));
		load_slot(7, enc_i(12'h1, 5'd1, F3_BYTE, 5'd7, OP_LOAD));
		// Unaligned halfword straddles the stored word and a clear byte.
		load_slot(8, enc_i(12'h3, 5'd1, F3_HALF, 5'd8, OP_LOAD));
		// Store below the window faults.
		load_slot(9, enc_s(12'hFFC, 5'd2, 5'd1, F3_WORD));
		load_slot(10, enc_b(32'd8, 5'd3, 5'd2, F3_BLT));
		load_slot(11, enc_i(12'h5, 5'd0, F3_ADD, 5'd10, OP_IMM));
		load_slot(12, enc_j(32'd8, 5'd11));
		load_slot(13, enc_r(F7_BASE, 5'd3, 5'd2, 3'd3, 5'd9));
		load_slot(14, enc_i(12'(ProgBase + 15 * 4 + 3), 5'd0, 3'd0, 5'd12, OP_JALR));
		load_slot(15, enc_i(12'h7, 5'd2, F3_ADD, 5'd0, OP_IMM));
		load_slot(16, {25'h1, OpFence});
		load_slot(17, enc_r(F7_BASE, 5'd2, 5'd2, 3'd3, 5'd13));
		load_slot(18, enc_j(-32'sd72, 5'd0));
		repeat (18) step_core();
		send_request(ACT_RDREG, 32'd4, $urandom);
		send_request(ACT_RDREG, 32'd33, $urandom);
		send_request(ACT_RDMEM, DataBaseRst, $urandom);
		send_request(ACT_RDMEM, DataBaseRst + 32'd4093, $urandom);
		send_request(ACT_LOAD, 32'h2, $urandom);
		send_request(ACT_LOAD, 32'h1000, $urandom);

		// Random phases, one window base and one idling pattern each.
		for (ph = 0; ph < 4; ph++) begin
			base = bases[ph];
			ptr_hi = 20'((base + 32'hFFF) >> 12);
			set_window(base);
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 71; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 71; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			if (ph == 0)
				for (int s = 0; s < ProgSlots; s++) load_slot(s, random_instr(s, ptr_hi));
			for (int k = 0; k < 250; k++) begin
				// Hold the sender until the core has drained once.
				if (ph == 1 && k == 125) begin
					push = 1'b0;
					while (outstanding != 0) @(negedge clk);
				end
				case ($urandom_range(0, 99)) inside
					[0:19]: begin
						addr = $urandom_range(0, ProgSlots - 1);
						load_slot(int'(addr), random_instr(int'(addr), ptr_hi));
					end
					[20:79]: step_core();
					[80:87]: send_request(ACT_RDREG,
						($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 31), $urandom);
					[88:95]: send_request(ACT_RDMEM,
						($urandom_range(0, 7) == 0) ? $urandom : base + $urandom_range(0, 4100),
						$urandom);
					default: begin
						addr = $urandom;
						if (addr[31:2] < InstWordsDef && addr[1:0] == 2'd0) addr[0] = 1'b1;
						send_request(ACT_LOAD, addr, $urandom);
					end
				endcase
			end
		end

		// Jump to an empty word, halt there, then keep stepping while halted.
		send_idle_pct = 0;
		stall_pct = 0;
		for (int s = 0; s < ProgSlots; s++)
			load_slot(s, enc_i(12'(HaltSpot), 5'd0, 3'd0, 5'd0, OP_JALR));
		repeat (3) step_core();
		send_request(ACT_RDREG, 32'd31, $urandom);
		send_request(ACT_RDMEM, $urandom, $urandom);
		send_request(ACT_LOAD, 32'h0, $urandom);
		step_core();

		// Drain and settle.
		wait_cycles = 0;
		while (outstanding != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (20) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire
